/* sv/ndts_pkg.sv */
// Shared types and constants for the numeric date text scanner.
`default_nettype none

package ndts_pkg;

   // Width of one decimal field value; the accumulator is four bits wider.
   localparam int FIELD_BITS = 16;
   localparam int ACC_BITS   = FIELD_BITS + 4;
   localparam int OUT_BITS   = 16;

   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_SLASH = 8'h2F;
   localparam logic [31:0] YEAR_BASE  = 32'd2000;
   localparam logic [31:0] YEAR_LOW   = 32'd10;
   localparam logic [31:0] YEAR_HIGH  = 32'd99;
   localparam logic [31:0] OUT_MAX    = 32'h0000_FFFF;

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      logic [2:0][FIELD_BITS-1:0] value;
      logic [2:0]                 seen;
      logic [1:0]                 slash_count;
      logic                       stopped;
   } scan_state_type;

   typedef struct packed {
      logic                valid_res;
      logic [OUT_BITS-1:0] day;
      logic [OUT_BITS-1:0] month;
      logic [OUT_BITS-1:0] year;
   } scan_result_type;

endpackage

`default_nettype wire

/* sv/ndts_step.sv */
// One character step of the date scan, plus result formation.
`default_nettype none

module ndts_step
   import ndts_pkg::*;
(
   input  wire logic [7:0]      ch,
   input  wire scan_state_type  cur,
   output scan_state_type       nxt,
   output scan_result_type      res
);

   logic                is_digit;
   logic [3:0]          digit;
   logic [1:0]          k;
   logic [ACC_BITS-1:0] acc;
   logic [ACC_BITS-1:0] base;
   logic [31:0]         year_wide;

   function automatic logic [OUT_BITS-1:0] clamp_out(input logic [31:0] v);
      clamp_out = (v > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : v[OUT_BITS-1:0];
   endfunction

   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign digit    = 4'(ch - CHAR_ZERO);
   // field index, pinned to the year field
   assign k        = (cur.slash_count == 2'd3) ? 2'd2 : cur.slash_count;
   assign base     = ACC_BITS'(cur.value[k]);
   // value*10 + digit
   assign acc      = (base << 3) + (base << 1) + ACC_BITS'(digit);

   always_comb begin
      nxt = cur;
      if (!cur.stopped) begin
         if (is_digit) begin
            if (|acc[ACC_BITS-1:FIELD_BITS]) begin
               nxt.value[k] = '1;
            end else begin
               nxt.value[k] = acc[FIELD_BITS-1:0];
            end
            nxt.seen[k] = 1'b1;
         end else if (ch == CHAR_SLASH) begin
            if (cur.slash_count >= 2'd2) begin
               nxt.stopped = 1'b1;
            end else begin
               nxt.slash_count = cur.slash_count + 2'd1;
            end
         end else if (cur.slash_count >= 2'd2) begin
            nxt.stopped = 1'b1;
         end else begin
            nxt.value       = '0;
            nxt.seen        = '0;
            nxt.slash_count = '0;
         end
      end
   end

   always_comb begin
      year_wide = 32'(nxt.value[2]);
      if ((year_wide >= YEAR_LOW) && (year_wide <= YEAR_HIGH)) begin
         year_wide = year_wide + YEAR_BASE;
      end
      res.valid_res = &nxt.seen;
      if (res.valid_res) begin
         res.day   = clamp_out(32'(nxt.value[0]));
         res.month = clamp_out(32'(nxt.value[1]));
         res.year  = clamp_out(year_wide);
      end else begin
         res.day   = '0;
         res.month = '0;
         res.year  = '0;
      end
   end

endmodule

`default_nettype wire

/* sv/numeric_date_text_scanner.sv */
// A last character goes through the input register, then the result register.
// Throughput: one character per cycle (one step pass each) unless a last one stalls.
// Results are held in an output register, so input keeps flowing while a result waits.
// Reset: synchronous, active high; clears the scan state and both valid flags.
// A stalled result holds the next last-character transaction and the input behind it.
`default_nettype none

module numeric_date_text_scanner
   import ndts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input characters
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,   // is_last
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] day, [31:16] month, [47:32] year
   output logic             rsp_tuser    // valid_res
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff,  in_char_in;
   logic        in_last_ff,  in_last_in;

   // scan state
   scan_state_type state_ff, state_in;
   scan_state_type step_next;
   scan_result_type step_res;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   scan_result_type rsp_ff, rsp_in;

   logic out_free;
   logic advance;

   ndts_step u_step (
      .ch  (in_char_ff),
      .cur (state_ff),
      .nxt (step_next),
      .res (step_res)
   );

   // Output slot is free if empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // A non-last character never waits; a last one needs the output slot.
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         // the last character closes the text: start clean for the next
         state_in = in_last_ff ? scan_state_type'('0) : step_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.year, rsp_ff.month, rsp_ff.day};
   assign rsp_tuser  = rsp_ff.valid_res;

endmodule

`default_nettype wire

/* sv/ndts_checker.sv */
// Port-level assertions for the numeric date text scanner, bound to the top level.
`default_nettype none

module ndts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // invalid result carries zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("invalid result with nonzero fields");

   // years from 10 to 99 always come out with the century added
   a_year_century: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !(rsp_tdata[47:32] >= 16'd10 && rsp_tdata[47:32] <= 16'd99))
      else $error("two-digit year not offset");

   // a fresh result follows an accepted last-character transaction
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without last-character transaction");

endmodule

bind numeric_date_text_scanner ndts_checker u_ndts_checker (.*);

`default_nettype wire
